// ===== design/band_color_table_macros.svh =====
// Assertion macros used by the band color table scan module.
`ifndef BAND_COLOR_TABLE_MACROS_SVH
`define BAND_COLOR_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BCT_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BCT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/bct_pkg.sv =====
// Types, constants and codes shared by the band color table modules.
package bct_pkg;

  localparam int unsigned TableDepth = 256;
  localparam int unsigned IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CntW = $clog2(TableDepth + 1);

  localparam logic OpRecord = 1'b0;
  localparam logic OpLookup = 1'b1;

  typedef enum logic [2:0] {
    StatUpdated  = 3'd0,
    StatAppended = 3'd1,
    StatDropped  = 3'd2,
    StatHit      = 3'd3,
    StatDefault  = 3'd4
  } status_e;

  typedef struct packed {
    logic [15:0] top;
    logic [14:0] height;
    logic [31:0] color;
  } entry_t;

  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] addr;
    entry_t          data;
  } wr_req_t;

  typedef struct packed {
    logic [31:0] color;
    status_e     status;
  } result_t;

endpackage

// ===== design/band_color_table.sv =====
// Top level of the band color table: configuration port, scan unit, memory and output register.
// A word is scanned against the table entries and its result is then held in the output register;
// a new word is accepted only after the result of the last one has left the scan unit.
// The scan reads one table entry per cycle.
// A lookup or matching record ends its scan at the first hit.
// Reset clears the entry count, the default color and the handshake state; the memory is not cleared.
module band_color_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        op_i,
  input  logic signed [15:0] row_top_i,
  input  logic [14:0] row_height_i,
  input  logic [31:0] fill_color_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] color_o,
  output logic [2:0]  status_o
);
  import bct_pkg::*;

  logic [31:0]     default_color_q;
  logic [IdxW-1:0] rd_addr;
  entry_t          rd_data;
  wr_req_t         wr_req;
  logic            res_valid;
  logic            res_ready;
  result_t         res;
  logic            out_valid_q;
  result_t         out_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? default_color_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      default_color_q <= '0;
    end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
      default_color_q <= pwdata;
    end
  end

  bct_scan u_scan (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .op_i            (op_i),
    .row_top_i       (row_top_i),
    .row_height_i    (row_height_i),
    .fill_color_i    (fill_color_i),
    .default_color_i (default_color_q),
    .rd_addr_o       (rd_addr),
    .rd_data_i       (rd_data),
    .wr_o            (wr_req),
    .res_valid_o     (res_valid),
    .res_ready_i     (res_ready),
    .res_o           (res)
  );

  bct_table u_table (
    .clk_i     (clk_i),
    .wr_i      (wr_req),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign color_o     = out_q.color;
  assign status_o    = out_q.status;

endmodule

// ===== design/bct_table.sv =====
// Band storage memory with one write port and one registered read port.
module bct_table (
  input  logic                  clk_i,
  input  bct_pkg::wr_req_t      wr_i,
  input  logic [bct_pkg::IdxW-1:0] rd_addr_i,
  output bct_pkg::entry_t       rd_data_o
);
  import bct_pkg::*;

  entry_t mem_q [TableDepth];

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule

// ===== design/bct_scan.sv =====
// Sequencer and shared compare unit that scans the band table one entry per cycle.
`include "band_color_table_macros.svh"

module bct_scan (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     op_i,
  input  logic signed [15:0]       row_top_i,
  input  logic [14:0]              row_height_i,
  input  logic [31:0]              fill_color_i,
  input  logic [31:0]              default_color_i,
  output logic [bct_pkg::IdxW-1:0] rd_addr_o,
  input  bct_pkg::entry_t          rd_data_i,
  output bct_pkg::wr_req_t         wr_o,
  output logic                     res_valid_o,
  input  logic                     res_ready_i,
  output bct_pkg::result_t         res_o
);
  import bct_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StFin  = 2'd2;

  logic [1:0]         state_q;
  logic [CntW-1:0]    cnt_q;
  logic [CntW-1:0]    addr_q;
  logic [CntW-1:0]    rd_idx_q;
  logic               rd_vld_q;
  logic               hit_q;
  logic               op_q;
  logic [15:0]        top_q;
  logic [14:0]        hgt_q;
  logic [31:0]        col_q;
  logic signed [16:0] bot_q;
  logic [IdxW-1:0]    hit_idx_q;
  logic [31:0]        hit_col_q;

  logic signed [16:0] item_bot;
  logic signed [16:0] ent_bot;
  logic               match;
  logic               last;
  logic               issue;
  logic               fire;
  logic               room;

  assign item_bot = $signed({row_top_i[15], row_top_i}) + $signed({2'b00, row_height_i});
  assign ent_bot  = $signed({rd_data_i.top[15], rd_data_i.top})
                  + $signed({2'b00, rd_data_i.height});

  always_comb begin
    if (op_q == OpRecord) begin
      match = (rd_data_i.top == top_q) && (rd_data_i.height == hgt_q);
    end else begin
      match = ($signed(top_q) >= $signed(rd_data_i.top)) && (bot_q <= ent_bot);
    end
  end

  assign last       = (rd_idx_q == (cnt_q - CntW'(1)));
  assign issue      = (state_q == StScan) && (addr_q < cnt_q);
  assign rd_addr_o  = addr_q[IdxW-1:0];
  assign in_ready_o = (state_q == StIdle);
  assign fire       = (state_q == StFin) && res_ready_i;
  assign room       = (cnt_q < CntW'(TableDepth));
  assign res_valid_o = fire;

  always_comb begin
    wr_o.we          = fire && (op_q == OpRecord) && (hit_q || room);
    wr_o.addr        = hit_q ? hit_idx_q : cnt_q[IdxW-1:0];
    wr_o.data.top    = top_q;
    wr_o.data.height = hgt_q;
    wr_o.data.color  = col_q;
    if (op_q == OpRecord) begin
      res_o.color = '0;
      if (hit_q) begin
        res_o.status = StatUpdated;
      end else if (room) begin
        res_o.status = StatAppended;
      end else begin
        res_o.status = StatDropped;
      end
    end else if (hit_q) begin
      res_o.color  = hit_col_q;
      res_o.status = StatHit;
    end else begin
      res_o.color  = default_color_i;
      res_o.status = StatDefault;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      cnt_q    <= '0;
      addr_q   <= '0;
      rd_idx_q <= '0;
      rd_vld_q <= 1'b0;
      hit_q    <= 1'b0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            addr_q   <= '0;
            rd_vld_q <= 1'b0;
            hit_q    <= 1'b0;
            state_q  <= (cnt_q == '0) ? StFin : StScan;
          end
        end
        StScan: begin
          if (issue) begin
            addr_q <= addr_q + CntW'(1);
          end
          rd_idx_q <= addr_q;
          if (rd_vld_q && match) begin
            hit_q    <= 1'b1;
            rd_vld_q <= 1'b0;
            state_q  <= StFin;
          end else if (rd_vld_q && last) begin
            rd_vld_q <= 1'b0;
            state_q  <= StFin;
          end else begin
            rd_vld_q <= issue;
          end
        end
        StFin: begin
          if (res_ready_i) begin
            state_q <= StIdle;
            if ((op_q == OpRecord) && !hit_q && room) begin
              cnt_q <= cnt_q + CntW'(1);
            end
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == StIdle) && in_valid_i) begin
      op_q  <= op_i;
      top_q <= row_top_i;
      hgt_q <= row_height_i;
      col_q <= fill_color_i;
      bot_q <= item_bot;
    end
    if ((state_q == StScan) && rd_vld_q && match) begin
      hit_idx_q <= rd_idx_q[IdxW-1:0];
      hit_col_q <= rd_data_i.color;
    end
  end

  `BCT_ASSERT_IMPL(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= CntW'(TableDepth), "count over depth")
  `BCT_ASSERT_IMPL(a_wr_in_fin, clk_i, rst_ni, wr_o.we, state_q == StFin, "write outside finish")
  `BCT_ASSERT_IMPL(a_rd_in_range, clk_i, rst_ni, rd_vld_q, rd_idx_q < cnt_q, "read past count")
  `BCT_ASSERT_NEXT(a_fire_idle, clk_i, rst_ni, fire, state_q == StIdle, "no return to idle")

endmodule
